### rtl/char_lcd_parallel_controller_assert.svh
// Assertion macros for the character LCD controller.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef CHAR_LCD_PARALLEL_CONTROLLER_ASSERT_SVH
`define CHAR_LCD_PARALLEL_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define LCDC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcdc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LCDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcdc: next-cycle check failed");

`else

`define LCDC_ASSERT_NOW(lbl, ante, cons)
`define LCDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/lcdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the character LCD controller.
// No dependencies.
package lcdc_pkg;

	localparam int BUFFER_CHARS = 32;
	localparam int BUF_AW       = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1;
	localparam int CNT_W        = 6;

	localparam logic [7:0] CLEAR_CMD = 8'h01;

	// Configuration register indexes
	localparam logic [2:0] REG_POWER_WAIT   = 3'd0;
	localparam logic [2:0] REG_CLEAR_WAIT   = 3'd1;
	localparam logic [2:0] REG_FUNCTION_SET = 3'd2;
	localparam logic [2:0] REG_DISPLAY_CTL  = 3'd3;
	localparam logic [2:0] REG_ENTRY_MODE   = 3'd4;

	localparam logic [7:0] RST_POWER_WAIT   = 8'd30;
	localparam logic [7:0] RST_CLEAR_WAIT   = 8'd1;
	localparam logic [7:0] RST_FUNCTION_SET = 8'h38;
	localparam logic [7:0] RST_DISPLAY_CTL  = 8'h0C;
	localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;

	// Request kinds
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_CHAR  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BUSY      = 2'd1;
	localparam logic [1:0] ST_NOT_READY = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	typedef enum logic [5:0] {
		STEP_WAIT       = 6'b000001,
		STEP_DISPCTL    = 6'b000010,
		STEP_CLEAR      = 6'b000100,
		STEP_CLRWAIT    = 6'b001000,
		STEP_ENTRY_DONE = 6'b010000,
		STEP_READY      = 6'b100000
	} init_step_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_DATA = 3'b010,
		MODE_CMD  = 3'b100
	} out_mode_t;

	typedef enum logic [2:0] {
		PH_SETUP = 3'b001,
		PH_FALL  = 3'b010,
		PH_DONE  = 3'b100
	} strobe_ph_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_value;
		logic       char_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       rs_level;
		logic       en_level;
		logic [7:0] data_bus;
		logic       ready_res;
		logic       busy_res;
	} out_item_t;

endpackage

### rtl/char_lcd_parallel_controller.sv
`timescale 1ns / 1ps
// Character LCD controller, 8-bit parallel bus: init sequencer, command and string output.
// Depends on lcdc_pkg, lcdc_ram and char_lcd_parallel_controller_assert.svh.
//
// Usage:
//  - Requests arrive on in_valid/in_ready/in_data (func, char_value, char_last); each one
//    gives exactly one result on out_valid/out_ready/out_data.
//  - func tick advances the power-up sequence, then the clear command or the string
//    output; clear and character requests answer ok, busy, not ready or overflow.
//  - Each result is registered in the output register, or in the skid register while
//    the receiver stalls. One request is taken per cycle while in_ready is high.
//  - Characters sit in a 32-entry RAM with registered read. The read address is the
//    next send index, so the character under output is always ready in the cycle of
//    its tick; a write to the same entry in the same cycle is forwarded.
//  - Results pass an output register and a one-entry skid register: while the
//    receiver stalls, one more request is taken, then in_ready drops until the
//    skid register drains.
//  - Reset brings back the register defaults, starts the power-up wait and empties
//    the output stages. The RAM needs no clearing pass; only entries written by the
//    current string are read.
//  - cfg_we writes cfg_data to register cfg_index at once; indexes past the list
//    are ignored.
module char_lcd_parallel_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lcdc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lcdc_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	// Configuration registers
	logic [7:0] power_wait_q, clear_wait_q, function_set_q, display_ctl_q, entry_mode_q;

	// Controller state
	lcdc_pkg::init_step_t step_q, step_d;
	lcdc_pkg::out_mode_t  mode_q, mode_d;
	lcdc_pkg::strobe_ph_t phase_q, phase_d;
	logic [7:0]                 wait_q, wait_d;
	logic [lcdc_pkg::CNT_W-1:0] send_q, send_d;
	logic [lcdc_pkg::CNT_W-1:0] load_q, load_d;
	logic [lcdc_pkg::CNT_W-1:0] load_base;
	logic                       loading_q, loading_d;
	logic                       rs_q, rs_d;
	logic                       en_q, en_d;
	logic [7:0]                 bus_q, bus_d;

	// Strobe request from the sequencer
	logic       strobe_go;
	logic       strobe_rs;
	logic [7:0] strobe_byte;
	logic       strobe_done;

	// Character store
	logic                        ram_we;
	logic [lcdc_pkg::BUF_AW-1:0] ram_waddr;
	logic [7:0]                  ram_wdata;
	logic [lcdc_pkg::BUF_AW-1:0] ram_raddr;
	logic [7:0]                  ram_rdata;
	logic                        fwd_hit_q;
	logic [7:0]                  fwd_data_q;
	logic [7:0]                  cur_char;

	// Output stages
	logic                accept;
	logic [1:0]          status;
	lcdc_pkg::out_item_t result;
	lcdc_pkg::out_item_t main_q, skid_q;
	logic                main_v_q, skid_v_q;
	logic                ready_now;
	logic                out_busy;

	assign accept      = in_valid && in_ready;
	assign ready_now   = (step_q == lcdc_pkg::STEP_READY);
	assign out_busy    = (mode_q == lcdc_pkg::MODE_DATA) || (mode_q == lcdc_pkg::MODE_CMD);
	assign strobe_done = (phase_q == lcdc_pkg::PH_DONE);
	assign cur_char    = fwd_hit_q ? fwd_data_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_wait_q   <= lcdc_pkg::RST_POWER_WAIT;
			clear_wait_q   <= lcdc_pkg::RST_CLEAR_WAIT;
			function_set_q <= lcdc_pkg::RST_FUNCTION_SET;
			display_ctl_q  <= lcdc_pkg::RST_DISPLAY_CTL;
			entry_mode_q   <= lcdc_pkg::RST_ENTRY_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdc_pkg::REG_POWER_WAIT:   power_wait_q   <= cfg_data;
				lcdc_pkg::REG_CLEAR_WAIT:   clear_wait_q   <= cfg_data;
				lcdc_pkg::REG_FUNCTION_SET: function_set_q <= cfg_data;
				lcdc_pkg::REG_DISPLAY_CTL:  display_ctl_q  <= cfg_data;
				lcdc_pkg::REG_ENTRY_MODE:   entry_mode_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		step_d      = step_q;
		mode_d      = mode_q;
		phase_d     = phase_q;
		wait_d      = wait_q;
		send_d      = send_q;
		load_d      = load_q;
		loading_d   = loading_q;
		rs_d        = rs_q;
		en_d        = en_q;
		bus_d       = bus_q;
		strobe_go   = 1'b0;
		strobe_rs   = 1'b0;
		strobe_byte = 8'h00;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = in_data.char_value;
		status      = lcdc_pkg::ST_OK;
		load_base   = loading_q ? load_q : '0;

		if (accept) begin
			unique case (in_data.func)
				lcdc_pkg::FUNC_TICK: begin
					if (ready_now) begin
						if (mode_q == lcdc_pkg::MODE_DATA) begin
							if ((send_q < load_q) &&
							    (send_q < lcdc_pkg::CNT_W'(lcdc_pkg::BUFFER_CHARS)) &&
							    (cur_char != 8'h00)) begin
								strobe_go   = 1'b1;
								strobe_rs   = 1'b1;
								strobe_byte = cur_char;
								if (strobe_done) begin
									send_d = send_q + 1'b1;
								end
							end else begin
								send_d = '0;
								mode_d = lcdc_pkg::MODE_IDLE;
							end
						end else if (mode_q == lcdc_pkg::MODE_CMD) begin
							strobe_go   = 1'b1;
							strobe_byte = lcdc_pkg::CLEAR_CMD;
							if (strobe_done) begin
								mode_d = lcdc_pkg::MODE_IDLE;
							end
						end
					end else begin
						unique case (step_q)
							lcdc_pkg::STEP_WAIT: begin
								if (wait_q == power_wait_q) begin
									strobe_go   = 1'b1;
									strobe_byte = function_set_q;
									if (strobe_done) begin
										step_d = lcdc_pkg::STEP_DISPCTL;
										wait_d = '0;
									end
								end else begin
									wait_d = wait_q + 1'b1;
								end
							end
							lcdc_pkg::STEP_DISPCTL: begin
								strobe_go   = 1'b1;
								strobe_byte = display_ctl_q;
								if (strobe_done) begin
									step_d = lcdc_pkg::STEP_CLEAR;
									wait_d = '0;
								end
							end
							lcdc_pkg::STEP_CLEAR: begin
								strobe_go   = 1'b1;
								strobe_byte = lcdc_pkg::CLEAR_CMD;
								if (strobe_done) begin
									step_d = lcdc_pkg::STEP_CLRWAIT;
									wait_d = '0;
								end
							end
							lcdc_pkg::STEP_CLRWAIT: begin
								if (wait_q == clear_wait_q) begin
									strobe_go   = 1'b1;
									strobe_byte = entry_mode_q;
									if (strobe_done) begin
										step_d = lcdc_pkg::STEP_ENTRY_DONE;
										wait_d = '0;
									end
								end else begin
									wait_d = wait_q + 1'b1;
								end
							end
							lcdc_pkg::STEP_ENTRY_DONE: begin
								step_d = lcdc_pkg::STEP_READY;
							end
							default: ;
						endcase
					end
				end
				lcdc_pkg::FUNC_CLEAR: begin
					if (!ready_now) begin
						status = lcdc_pkg::ST_NOT_READY;
					end else if (out_busy || loading_q) begin
						status = lcdc_pkg::ST_BUSY;
					end else begin
						mode_d = lcdc_pkg::MODE_CMD;
					end
				end
				lcdc_pkg::FUNC_CHAR: begin
					if (!ready_now) begin
						status = lcdc_pkg::ST_NOT_READY;
					end else if (out_busy) begin
						status = lcdc_pkg::ST_BUSY;
					end else begin
						loading_d = 1'b1;
						load_d    = load_base;
						if (load_base < lcdc_pkg::CNT_W'(lcdc_pkg::BUFFER_CHARS)) begin
							ram_we    = 1'b1;
							ram_waddr = load_base[lcdc_pkg::BUF_AW-1:0];
							load_d    = load_base + 1'b1;
						end else begin
							status = lcdc_pkg::ST_OVERFLOW;
						end
						if (in_data.char_last) begin
							loading_d = 1'b0;
							send_d    = '0;
							mode_d    = lcdc_pkg::MODE_DATA;
						end
					end
				end
				default: ;
			endcase
		end

		// Byte strobe: setup with EN high, drop EN, then finish
		if (strobe_go) begin
			unique case (phase_q)
				lcdc_pkg::PH_SETUP: begin
					rs_d    = strobe_rs;
					en_d    = 1'b1;
					bus_d   = strobe_byte;
					phase_d = lcdc_pkg::PH_FALL;
				end
				lcdc_pkg::PH_FALL: begin
					en_d    = 1'b0;
					phase_d = lcdc_pkg::PH_DONE;
				end
				default: begin
					phase_d = lcdc_pkg::PH_SETUP;
				end
			endcase
		end

		ram_raddr = send_d[lcdc_pkg::BUF_AW-1:0];

		result.status    = status;
		result.rs_level  = rs_d;
		result.en_level  = en_d;
		result.data_bus  = bus_d;
		result.ready_res = (step_d == lcdc_pkg::STEP_READY);
		result.busy_res  = (mode_d == lcdc_pkg::MODE_DATA) || (mode_d == lcdc_pkg::MODE_CMD) ||
		                   loading_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= lcdc_pkg::STEP_WAIT;
			mode_q    <= lcdc_pkg::MODE_IDLE;
			phase_q   <= lcdc_pkg::PH_SETUP;
			wait_q    <= '0;
			send_q    <= '0;
			load_q    <= '0;
			loading_q <= 1'b0;
			rs_q      <= 1'b0;
			en_q      <= 1'b0;
			bus_q     <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			step_q    <= step_d;
			mode_q    <= mode_d;
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			send_q    <= send_d;
			load_q    <= load_d;
			loading_q <= loading_d;
			rs_q      <= rs_d;
			en_q      <= en_d;
			bus_q     <= bus_d;
			// forward a write that lands on the entry being read
			fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
	end

	lcdc_ram #(
		.WIDTH(8),
		.DEPTH(lcdc_pkg::BUFFER_CHARS)
	) u_char_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register with a skid stage
	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !main_v_q) begin
			main_v_q <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_v_q) begin
			main_q <= skid_v_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

`include "char_lcd_parallel_controller_assert.svh"

	`LCDC_ASSERT_NOW(a_load_not_during_output, loading_q, mode_q == lcdc_pkg::MODE_IDLE)
	`LCDC_ASSERT_NOW(a_load_within_buffer, 1'b1,
		load_q <= lcdc_pkg::CNT_W'(lcdc_pkg::BUFFER_CHARS))
	`LCDC_ASSERT_NOW(a_skid_behind_main, skid_v_q, main_v_q)
	`LCDC_ASSERT_NOW(a_en_high_only_in_fall, en_q, phase_q == lcdc_pkg::PH_FALL)

endmodule

### rtl/lcdc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### test/char_lcd_parallel_controller_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the character LCD controller: power-up sequence, clear and
// string requests under random idling and back-pressure, checked against a local predictor.
// Depends on lcdc_pkg and the char_lcd_parallel_controller RTL.
module char_lcd_parallel_controller_test;
	import lcdc_pkg::*;

	localparam int CYCLE_LIMIT      = 300000;
	localparam int RANDOM_PER_PHASE = 180;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int mismatches;
	int requests_sent;
	int cycles;

	out_item_t expected_pins[$];
	out_item_t pins_due;

	// Predictor state
	logic [7:0] lcd_cfg [5];
	init_step_t lcd_step;
	logic [7:0] lcd_wait;
	logic       lcd_ready;
	out_mode_t  lcd_mode;
	strobe_ph_t lcd_phase;
	logic [7:0] lcd_store [BUFFER_CHARS];
	logic [5:0] lcd_send_idx;
	logic [5:0] lcd_load_cnt;
	logic       lcd_loading;
	logic       lcd_rs;
	logic       lcd_en;
	logic [7:0] lcd_bus;

	char_lcd_parallel_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** char_lcd_parallel_controller: FAILED **");
		$finish;
	end

	// Receiver: a long hold-off when asked, otherwise random stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic bit strobe_byte(input logic [7:0] b, input logic is_data);
		bit done;
		done = 1'b0;
		case (lcd_phase)
			PH_SETUP: begin
				lcd_rs = is_data;
				lcd_en = 1'b1;
				lcd_bus = b;
				lcd_phase = PH_FALL;
			end
			PH_FALL: begin
				lcd_en = 1'b0;
				lcd_phase = PH_DONE;
			end
			default: begin
				lcd_phase = PH_SETUP;
				done = 1'b1;
			end
		endcase
		return done;
	endfunction

	function automatic void advance_init();
		case (lcd_step)
			STEP_WAIT: begin
				// count up with 8-bit wrap until the register matches
				if (lcd_wait == lcd_cfg[REG_POWER_WAIT]) begin
					if (strobe_byte(lcd_cfg[REG_FUNCTION_SET], 1'b0)) begin
						lcd_step = STEP_DISPCTL;
						lcd_wait = '0;
					end
				end else begin
					lcd_wait = lcd_wait + 8'd1;
				end
			end
			STEP_DISPCTL: begin
				if (strobe_byte(lcd_cfg[REG_DISPLAY_CTL], 1'b0)) begin
					lcd_step = STEP_CLEAR;
					lcd_wait = '0;
				end
			end
			STEP_CLEAR: begin
				if (strobe_byte(CLEAR_CMD, 1'b0)) begin
					lcd_step = STEP_CLRWAIT;
					lcd_wait = '0;
				end
			end
			STEP_CLRWAIT: begin
				if (lcd_wait == lcd_cfg[REG_CLEAR_WAIT]) begin
					if (strobe_byte(lcd_cfg[REG_ENTRY_MODE], 1'b0)) begin
						lcd_step = STEP_ENTRY_DONE;
						lcd_wait = '0;
					end
				end else begin
					lcd_wait = lcd_wait + 8'd1;
				end
			end
			STEP_ENTRY_DONE: begin
				lcd_step = STEP_READY;
				lcd_ready = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic void advance_output();
		int idx;
		idx = lcd_send_idx;
		if (lcd_mode == MODE_DATA) begin
			if (idx < lcd_load_cnt && idx < BUFFER_CHARS && lcd_store[idx] != 8'h00) begin
				if (strobe_byte(lcd_store[idx], 1'b1))
					lcd_send_idx = lcd_send_idx + 6'd1;
			end else begin
				// end of string or a zero character: stop
				lcd_send_idx = '0;
				lcd_mode = MODE_IDLE;
			end
		end else if (lcd_mode == MODE_CMD) begin
			if (strobe_byte(CLEAR_CMD, 1'b0))
				lcd_mode = MODE_IDLE;
		end
	endfunction

	function automatic out_item_t predict_pins(input in_item_t req);
		out_item_t res;
		res = '0;
		res.status = ST_OK;
		case (req.func)
			FUNC_TICK: begin
				if (lcd_ready)
					advance_output();
				else
					advance_init();
			end
			FUNC_CLEAR: begin
				if (!lcd_ready)
					res.status = ST_NOT_READY;
				else if (lcd_mode != MODE_IDLE || lcd_loading)
					res.status = ST_BUSY;
				else
					lcd_mode = MODE_CMD;
			end
			FUNC_CHAR: begin
				if (!lcd_ready) begin
					res.status = ST_NOT_READY;
				end else if (lcd_mode != MODE_IDLE) begin
					res.status = ST_BUSY;
				end else begin
					if (!lcd_loading) begin
						lcd_loading = 1'b1;
						lcd_load_cnt = '0;
					end
					if (lcd_load_cnt < BUFFER_CHARS) begin
						lcd_store[lcd_load_cnt] = req.char_value;
						lcd_load_cnt = lcd_load_cnt + 6'd1;
					end else begin
						res.status = ST_OVERFLOW;
					end
					// a dropped last character still closes the load
					if (req.char_last) begin
						lcd_loading = 1'b0;
						lcd_send_idx = '0;
						lcd_mode = MODE_DATA;
					end
				end
			end
			default: ;
		endcase
		res.rs_level = lcd_rs;
		res.en_level = lcd_en;
		res.data_bus = lcd_bus;
		res.ready_res = lcd_ready;
		res.busy_res = (lcd_mode != MODE_IDLE) || lcd_loading;
		return res;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				report_mismatch("unrequested result", 16'(out_data), 16'h0);
			end else begin
				pins_due = expected_pins.pop_front();
				if (out_data.status !== pins_due.status)
					report_mismatch("status", 16'(out_data.status),
						16'(pins_due.status));
				if (out_data.rs_level !== pins_due.rs_level)
					report_mismatch("rs_level", 16'(out_data.rs_level),
						16'(pins_due.rs_level));
				if (out_data.en_level !== pins_due.en_level)
					report_mismatch("en_level", 16'(out_data.en_level),
						16'(pins_due.en_level));
				if (out_data.data_bus !== pins_due.data_bus)
					report_mismatch("data_bus", 16'(out_data.data_bus),
						16'(pins_due.data_bus));
				if (out_data.ready_res !== pins_due.ready_res)
					report_mismatch("ready_res", 16'(out_data.ready_res),
						16'(pins_due.ready_res));
				if (out_data.busy_res !== pins_due.busy_res)
					report_mismatch("busy_res", 16'(out_data.busy_res),
						16'(pins_due.busy_res));
			end
		end
	end

	// ---------------------------------------------------------------- driving

	task automatic send_request(input logic [1:0] func, input logic [7:0] ch,
			input logic last);
		in_item_t req;
		req.func = func;
		req.char_value = ch;
		req.char_last = last;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		expected_pins.push_back(predict_pins(req));
		requests_sent++;
	endtask

	// Ticks carry random character fields, which the block must ignore
	task automatic send_tick();
		send_request(FUNC_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pins.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		lcd_cfg[idx] = val;
	endtask

	task automatic write_all_regs(input logic [7:0] pw, input logic [7:0] cw,
			input logic [7:0] fs, input logic [7:0] dc, input logic [7:0] em);
		wait_results_drained();
		write_reg(REG_POWER_WAIT, pw);
		write_reg(REG_CLEAR_WAIT, cw);
		write_reg(REG_FUNCTION_SET, fs);
		write_reg(REG_DISPLAY_CTL, dc);
		write_reg(REG_ENTRY_MODE, em);
	endtask

	// Tick until output is idle, now and then throwing in a request that must bounce
	task automatic flush_output(input int busy_pct);
		while (lcd_mode != MODE_IDLE) begin
			if ($urandom_range(99) < busy_pct) begin
				if ($urandom_range(1))
					send_request(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
				else
					send_request(FUNC_CHAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				send_tick();
			end
		end
	endtask

	task automatic send_string(input int len, input int zero_pct, input int tick_pct);
		logic [7:0] ch;
		for (int i = 0; i < len; i++) begin
			while ($urandom_range(99) < tick_pct)
				send_tick();
			if ($urandom_range(99) < 4)
				send_request(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			ch = ($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
			send_request(FUNC_CHAR, ch, i == len - 1);
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_power_up();
		int n;
		n = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all_regs(8'd4, 8'd255, 8'hFF, 8'h00, 8'hA5);
		send_request(FUNC_CLEAR, 8'h00, 1'b0);
		send_request(FUNC_CHAR, 8'hFF, 1'b1);
		send_request(FUNC_UNUSED, 8'h00, 1'b0);
		repeat (3) send_tick();
		// drop the limit below the running count: the counter must wrap
		wait_results_drained();
		write_reg(REG_POWER_WAIT, 8'd2);
		while (!lcd_ready) begin
			n++;
			if (n % 64 == 0)
				send_request(FUNC_CHAR, 8'($urandom_range(255)), 1'b1);
			else
				send_tick();
		end
	endtask

	task automatic test_requests();
		send_request(FUNC_CLEAR, 8'hFF, 1'b1);
		send_request(FUNC_CLEAR, 8'h00, 1'b0);
		send_request(FUNC_CHAR, 8'h55, 1'b1);
		flush_output(0);
		// ticks and a clear during a load change nothing
		send_request(FUNC_CHAR, 8'h41, 1'b0);
		send_tick();
		send_request(FUNC_CLEAR, 8'h00, 1'b0);
		send_request(FUNC_CHAR, 8'hFF, 1'b0);
		send_request(FUNC_CHAR, 8'h7E, 1'b1);
		send_tick();
		send_request(FUNC_CHAR, 8'h20, 1'b1);
		send_request(FUNC_CLEAR, 8'h00, 1'b0);
		flush_output(0);
		// a zero character stops output there
		send_request(FUNC_CHAR, 8'h31, 1'b0);
		send_request(FUNC_CHAR, 8'h00, 1'b0);
		send_request(FUNC_CHAR, 8'h32, 1'b1);
		flush_output(0);
		send_request(FUNC_CHAR, 8'h00, 1'b1);
		flush_output(0);
		send_request(FUNC_UNUSED, 8'hFF, 1'b1);
		send_request(FUNC_UNUSED, 8'h00, 1'b0);
	endtask

	task automatic test_overflow();
		send_string(BUFFER_CHARS + 2, 0, 0);
		flush_output(0);
		send_string(BUFFER_CHARS + 8, 0, 10);
		flush_output(0);
	endtask

	task automatic test_backpressure();
		wait_results_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 60;
		send_string(24, 0, 0);
		flush_output(0);
		// hold the sender until every result is in, then carry on
		wait_results_drained();
		send_string(5, 0, 0);
		flush_output(0);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct,
			input logic [7:0] pw, input logic [7:0] cw, input logic [7:0] fs,
			input logic [7:0] dc, input logic [7:0] em);
		int stop_at;
		int sel;
		int len;
		// the init registers no longer matter once the power-up has run
		write_all_regs(pw, cw, fs, dc, em);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = requests_sent + RANDOM_PER_PHASE;
		while (requests_sent < stop_at) begin
			sel = $urandom_range(99);
			if (sel < 65) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(BUFFER_CHARS + 1, BUFFER_CHARS + 8);
				else
					len = $urandom_range(1, BUFFER_CHARS);
				send_string(len, 5, 20);
				flush_output(10);
			end else if (sel < 75) begin
				send_request(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
				flush_output(10);
			end else if (sel < 88) begin
				send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(1, 8)) send_tick();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		mismatches = 0;
		requests_sent = 0;

		lcd_cfg[REG_POWER_WAIT] = RST_POWER_WAIT;
		lcd_cfg[REG_CLEAR_WAIT] = RST_CLEAR_WAIT;
		lcd_cfg[REG_FUNCTION_SET] = RST_FUNCTION_SET;
		lcd_cfg[REG_DISPLAY_CTL] = RST_DISPLAY_CTL;
		lcd_cfg[REG_ENTRY_MODE] = RST_ENTRY_MODE;
		lcd_step = STEP_WAIT;
		lcd_wait = '0;
		lcd_ready = 1'b0;
		lcd_mode = MODE_IDLE;
		lcd_phase = PH_SETUP;
		lcd_send_idx = '0;
		lcd_load_cnt = '0;
		lcd_loading = 1'b0;
		lcd_rs = 1'b0;
		lcd_en = 1'b0;
		lcd_bus = '0;
		for (int i = 0; i < BUFFER_CHARS; i++)
			lcd_store[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_power_up();
		test_requests();
		test_overflow();
		test_backpressure();
		test_random(0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		test_random(80, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		test_random(0, 80, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random(8, 8, RST_POWER_WAIT, RST_CLEAR_WAIT, RST_FUNCTION_SET,
			RST_DISPLAY_CTL, RST_ENTRY_MODE);

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** char_lcd_parallel_controller: PASSED **");
		else
			$display("** char_lcd_parallel_controller: FAILED **");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/lcdc_pkg.sv
rtl/lcdc_ram.sv
rtl/char_lcd_parallel_controller.sv
test/char_lcd_parallel_controller_test.sv
